// File: hw/rtl/printer_spool_record_parser_assert.svh
// Assertion macros for the spool record parser.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef PRINTER_SPOOL_RECORD_PARSER_ASSERT_SVH
`define PRINTER_SPOOL_RECORD_PARSER_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define PSPR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle
`define PSPR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pspr_pkg.sv
// Package for the spool record parser: codes, constants, types.
// No dependencies.
`timescale 1ns / 1ps
package pspr_pkg;

  // Stream bytes
  localparam logic [7:0] ESC_BYTE     = 8'h1b;
  localparam logic [7:0] CMD_FOOTER   = 8'h50;
  localparam logic [7:0] CMD_JOB      = 8'h51;
  localparam logic [7:0] CMD_GENERAL  = 8'h57;
  localparam logic [7:0] CMD_COMMENT  = 8'h58;
  localparam logic [7:0] CMD_PLANE    = 8'h5a;
  localparam logic [7:0] SUB_PLANE    = 8'h74;
  localparam logic [7:0] SUB_CLEAR    = 8'h43;
  localparam logic [7:0] GEN_LEN_MARK = 8'd46;
  localparam logic [7:0] COPIES_CONT  = 8'hff;
  localparam logic [7:0] SEL_SETUP_B  = 8'h20;
  localparam logic [7:0] SEL_OPTS_B   = 8'h21;
  localparam logic [7:0] SEL_GAMMA_B  = 8'h22;

  // Record lengths and byte positions
  localparam logic [5:0] GEN_LEN       = 6'd50;
  localparam logic [5:0] COMMENT_LEN_0 = 6'd36;
  localparam logic [5:0] COMMENT_LEN_1 = 6'd42;
  localparam logic [5:0] PLANE_LEN     = 6'd12;
  localparam logic [5:0] PLANE_DIM_LO  = 6'd8;
  localparam logic [5:0] PLANE_DIM_HI  = 6'd10;
  localparam logic [5:0] IDX_SELECT    = 6'd2;
  localparam logic [5:0] IDX_LEN_MARK  = 6'd3;
  localparam logic [5:0] IDX_SETUP_FIX = 6'd18;
  localparam logic [5:0] IDX_COPIES    = 6'd13;

  // Record kinds
  localparam logic [3:0] KIND_ESC     = 4'd0;
  localparam logic [3:0] KIND_PENDING = 4'd1;
  localparam logic [3:0] KIND_CLEAR   = 4'd2;
  localparam logic [3:0] KIND_JOB     = 4'd3;
  localparam logic [3:0] KIND_GENERAL = 4'd4;
  localparam logic [3:0] KIND_COMMENT = 4'd5;
  localparam logic [3:0] KIND_PLANE   = 4'd6;
  localparam logic [3:0] KIND_IMAGE   = 4'd7;
  localparam logic [3:0] KIND_FOOTER  = 4'd8;

  // General header numbers
  localparam logic [2:0] HDR_UNKNOWN = 3'd0;
  localparam logic [2:0] HDR_SETUP   = 3'd1;
  localparam logic [2:0] HDR_OPTIONS = 3'd2;
  localparam logic [2:0] HDR_GAMMA   = 3'd3;
  localparam logic [2:0] HDR_OTHER   = 3'd4;

  // Error codes
  localparam logic [2:0] ERR_OK          = 3'd0;
  localparam logic [2:0] ERR_NO_ESC      = 3'd1;
  localparam logic [2:0] ERR_UNKNOWN_CMD = 3'd2;
  localparam logic [2:0] ERR_BAD_LEN     = 3'd3;
  localparam logic [2:0] ERR_BAD_SUBTYPE = 3'd4;
  localparam logic [2:0] ERR_EARLY_END   = 3'd5;

  // Configuration register indexes
  localparam logic CFG_PRINTER_MODEL    = 1'b0;
  localparam logic CFG_REQUESTED_COPIES = 1'b1;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_CMD     = 7'b0000010,
    PH_GEN     = 7'b0000100,
    PH_COMMENT = 7'b0001000,
    PH_PEND    = 7'b0010000,
    PH_PLANE   = 7'b0100000,
    PH_IMAGE   = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] record_kind;
    logic [2:0] header_number;
    logic [5:0] byte_index;
    logic       record_last;
    logic       job_done;
    logic [2:0] error_code;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

endpackage

// File: hw/rtl/pspr_if.sv
// Handshake interfaces for the spool record parser channels.
// No dependencies.
`timescale 1ns / 1ps
interface pspr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;
  modport source (output valid, data_byte, stream_end, input ready);
  modport sink   (input valid, data_byte, stream_end, output ready);
endinterface

interface pspr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [3:0] record_kind;
  logic [2:0] header_number;
  logic [5:0] byte_index;
  logic       record_last;
  logic       job_done;
  logic [2:0] error_code;
  modport source (output valid, out_byte, record_kind, header_number, byte_index,
                  record_last, job_done, error_code, input ready);
  modport sink   (input valid, out_byte, record_kind, header_number, byte_index,
                  record_last, job_done, error_code, output ready);
endinterface

interface pspr_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/pspr_in_reg.sv
// Input register of the spool record parser.
// Depends on pspr_pkg.
`timescale 1ns / 1ps
module pspr_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [7:0]         data_byte_i,
  input  logic               stream_end_i,
  input  logic               take_i,
  output logic               ready_o,
  output pspr_pkg::in_item_t item_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       end_q;

  // Accept a new byte when empty or when the held one moves on
  assign ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Load payload on a transfer
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= data_byte_i;
      end_q  <= stream_end_i;
    end
  end

  assign item_o.valid      = valid_q;
  assign item_o.data_byte  = byte_q;
  assign item_o.stream_end = end_q;

endmodule

// File: hw/rtl/pspr_parser.sv
// Parse state and per-byte tagging/patching logic of the spool record parser.
// Depends on pspr_pkg.
`timescale 1ns / 1ps
module pspr_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        data_byte_i,
  input  logic              stream_end_i,
  input  logic              printer_model_i,
  input  logic [7:0]        requested_copies_i,
  output pspr_pkg::result_t result_o
);

  localparam logic [5:0] IDX_SUB = 6'd2;

  pspr_pkg::phase_e phase_q, phase_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [2:0]  sel_q, sel_d;
  logic [23:0] dim_q, dim_d;
  logic [31:0] rem_q, rem_d;

  logic [5:0]  cnt_inc;
  logic [5:0]  comment_len;
  logic [15:0] cols;
  logic [15:0] rows;
  logic [31:0] rem_dec;
  logic [2:0]  sel_now;
  pspr_pkg::result_t res;

  assign cnt_inc     = cnt_q + 6'd1;
  assign comment_len = printer_model_i ? pspr_pkg::COMMENT_LEN_1 : pspr_pkg::COMMENT_LEN_0;
  assign cols        = dim_q[23:8];
  assign rows        = {dim_q[7:0], data_byte_i};
  assign rem_dec     = (rem_q != 32'd0) ? rem_q - 32'd1 : rem_q;

  // Work out the result and next state for the byte in the input register
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    cmd_d   = cmd_q;
    sel_d   = sel_q;
    dim_d   = dim_q;
    rem_d   = rem_q;
    sel_now = sel_q;
    res.out_byte      = data_byte_i;
    res.record_kind   = pspr_pkg::KIND_ESC;
    res.header_number = pspr_pkg::HDR_UNKNOWN;
    res.byte_index    = 6'd0;
    res.record_last   = 1'b0;
    res.job_done      = 1'b0;
    res.error_code    = pspr_pkg::ERR_OK;

    if (stream_end_i) begin
      res.out_byte   = 8'd0;
      res.error_code = pspr_pkg::ERR_EARLY_END;
      phase_d        = pspr_pkg::PH_IDLE;
      cnt_d          = 6'd0;
    end else begin
      case (phase_q)
        pspr_pkg::PH_IDLE: begin
          if (data_byte_i != pspr_pkg::ESC_BYTE) begin
            res.error_code = pspr_pkg::ERR_NO_ESC;
          end else begin
            phase_d = pspr_pkg::PH_CMD;
            cnt_d   = 6'd1;
          end
        end
        pspr_pkg::PH_CMD: begin
          res.byte_index = 6'd1;
          cmd_d          = data_byte_i;
          case (data_byte_i)
            pspr_pkg::CMD_FOOTER: begin
              res.record_kind = pspr_pkg::KIND_FOOTER;
              res.record_last = 1'b1;
              res.job_done    = 1'b1;
              phase_d         = pspr_pkg::PH_IDLE;
              cnt_d           = 6'd0;
            end
            pspr_pkg::CMD_JOB: begin
              res.record_kind = pspr_pkg::KIND_JOB;
              res.record_last = 1'b1;
              phase_d         = pspr_pkg::PH_IDLE;
              cnt_d           = 6'd0;
            end
            pspr_pkg::CMD_GENERAL: begin
              res.record_kind = pspr_pkg::KIND_GENERAL;
              sel_d           = pspr_pkg::HDR_UNKNOWN;
              phase_d         = pspr_pkg::PH_GEN;
              cnt_d           = 6'd2;
            end
            pspr_pkg::CMD_COMMENT: begin
              res.record_kind = pspr_pkg::KIND_COMMENT;
              phase_d         = pspr_pkg::PH_COMMENT;
              cnt_d           = 6'd2;
            end
            pspr_pkg::CMD_PLANE: begin
              res.record_kind = pspr_pkg::KIND_PENDING;
              phase_d         = pspr_pkg::PH_PEND;
              cnt_d           = 6'd2;
            end
            default: begin
              res.error_code = pspr_pkg::ERR_UNKNOWN_CMD;
              phase_d        = pspr_pkg::PH_IDLE;
              cnt_d          = 6'd0;
            end
          endcase
        end
        pspr_pkg::PH_GEN: begin
          // Byte 2 picks the header; it tags the same byte
          if (cnt_q == pspr_pkg::IDX_SELECT) begin
            case (data_byte_i)
              pspr_pkg::SEL_SETUP_B: sel_now = pspr_pkg::HDR_SETUP;
              pspr_pkg::SEL_OPTS_B:  sel_now = pspr_pkg::HDR_OPTIONS;
              pspr_pkg::SEL_GAMMA_B: sel_now = pspr_pkg::HDR_GAMMA;
              default:               sel_now = pspr_pkg::HDR_OTHER;
            endcase
            sel_d = sel_now;
          end
          if (cnt_q == pspr_pkg::IDX_LEN_MARK && data_byte_i != pspr_pkg::GEN_LEN_MARK) begin
            res.error_code = pspr_pkg::ERR_BAD_LEN;
            phase_d        = pspr_pkg::PH_IDLE;
            cnt_d          = 6'd0;
          end else begin
            res.record_kind   = pspr_pkg::KIND_GENERAL;
            res.byte_index    = cnt_q;
            res.header_number = sel_now;
            // Patch the setup flag and the copy count
            if (sel_now == pspr_pkg::HDR_SETUP && cnt_q == pspr_pkg::IDX_SETUP_FIX &&
                !printer_model_i && data_byte_i == 8'd0) begin
              res.out_byte = 8'd1;
            end
            if (sel_now == pspr_pkg::HDR_OPTIONS && cnt_q == pspr_pkg::IDX_COPIES &&
                data_byte_i != pspr_pkg::COPIES_CONT && requested_copies_i > data_byte_i) begin
              res.out_byte = requested_copies_i;
            end
            cnt_d = cnt_inc;
            if (cnt_inc >= pspr_pkg::GEN_LEN) begin
              res.record_last = 1'b1;
              phase_d         = pspr_pkg::PH_IDLE;
              cnt_d           = 6'd0;
            end
          end
        end
        pspr_pkg::PH_COMMENT: begin
          res.record_kind = pspr_pkg::KIND_COMMENT;
          res.byte_index  = cnt_q;
          cnt_d           = cnt_inc;
          if (cnt_inc >= comment_len) begin
            res.record_last = 1'b1;
            phase_d         = pspr_pkg::PH_IDLE;
            cnt_d           = 6'd0;
          end
        end
        pspr_pkg::PH_PEND: begin
          if (cnt_q == IDX_SUB) begin
            res.record_kind = pspr_pkg::KIND_PENDING;
            res.byte_index  = IDX_SUB;
            cmd_d           = data_byte_i;
            cnt_d           = 6'd3;
          end else if (cmd_q == pspr_pkg::SUB_CLEAR) begin
            res.record_kind = pspr_pkg::KIND_CLEAR;
            res.byte_index  = 6'd3;
            res.record_last = 1'b1;
            phase_d         = pspr_pkg::PH_IDLE;
            cnt_d           = 6'd0;
          end else if (cmd_q == pspr_pkg::SUB_PLANE) begin
            res.record_kind = pspr_pkg::KIND_PLANE;
            res.byte_index  = 6'd3;
            dim_d           = 24'd0;
            phase_d         = pspr_pkg::PH_PLANE;
            cnt_d           = 6'd4;
          end else begin
            res.error_code = pspr_pkg::ERR_BAD_SUBTYPE;
            phase_d        = pspr_pkg::PH_IDLE;
            cnt_d          = 6'd0;
          end
        end
        pspr_pkg::PH_PLANE: begin
          res.record_kind = pspr_pkg::KIND_PLANE;
          res.byte_index  = cnt_q;
          // Shift in columns and the high byte of rows
          if (cnt_q >= pspr_pkg::PLANE_DIM_LO && cnt_q <= pspr_pkg::PLANE_DIM_HI) begin
            dim_d = {dim_q[15:0], data_byte_i};
          end
          cnt_d = cnt_inc;
          if (cnt_inc >= pspr_pkg::PLANE_LEN) begin
            res.record_last = 1'b1;
            rem_d           = cols * rows;
            if (cols == 16'd0 || rows == 16'd0) begin
              phase_d = pspr_pkg::PH_IDLE;
            end else begin
              phase_d = pspr_pkg::PH_IMAGE;
            end
            cnt_d = 6'd0;
          end
        end
        pspr_pkg::PH_IMAGE: begin
          res.record_kind = pspr_pkg::KIND_IMAGE;
          rem_d           = rem_dec;
          if (rem_dec == 32'd0) begin
            res.record_last = 1'b1;
            phase_d         = pspr_pkg::PH_IDLE;
            cnt_d           = 6'd0;
          end
        end
        default: begin
          res.error_code = pspr_pkg::ERR_NO_ESC;
          phase_d        = pspr_pkg::PH_IDLE;
          cnt_d          = 6'd0;
        end
      endcase

      // On error drop every tag and pass the raw byte
      if (res.error_code != pspr_pkg::ERR_OK) begin
        res.record_kind   = pspr_pkg::KIND_ESC;
        res.header_number = pspr_pkg::HDR_UNKNOWN;
        res.byte_index    = 6'd0;
        res.record_last   = 1'b0;
        res.job_done      = 1'b0;
      end
    end
  end

  // Advance the parse state on each byte that moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pspr_pkg::PH_IDLE;
      cnt_q   <= 6'd0;
      cmd_q   <= 8'd0;
      sel_q   <= 3'd0;
      dim_q   <= 24'd0;
      rem_q   <= 32'd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      cmd_q   <= cmd_d;
      sel_q   <= sel_d;
      dim_q   <= dim_d;
      rem_q   <= rem_d;
    end
  end

  assign result_o = res;

endmodule

// File: hw/rtl/pspr_out_reg.sv
// Result register of the spool record parser.
// Depends on pspr_pkg.
`timescale 1ns / 1ps
module pspr_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  pspr_pkg::result_t result_i,
  input  logic              ready_i,
  output logic              can_load_o,
  output logic              valid_o,
  output pspr_pkg::result_t result_o
);

  logic              valid_q;
  pspr_pkg::result_t result_q;

  // Room for a new result when empty or when the held one is taken
  assign can_load_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load_o && load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// File: hw/rtl/printer_spool_record_parser.sv
// Path: a byte taken into the input register is parsed, then held in the result register.
// Throughput: one byte per cycle unless the result register is blocked; the longest
// path is the 16x16 rows-by-columns product on the last plane header byte.
// Reset: parser idle awaiting escape, all counters zero, printer_model 0,
// requested_copies 1; input and result registers empty.
`timescale 1ns / 1ps
`include "printer_spool_record_parser_assert.svh"
// Top level of the spool record parser: config registers, pipeline wiring.
// Depends on pspr_pkg, pspr_if, pspr_in_reg, pspr_parser, pspr_out_reg.
module printer_spool_record_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  pspr_in_if.sink     in_i,
  pspr_out_if.source  out_o,
  pspr_cfg_if.sink    cfg_i
);

  logic       printer_model_q;
  logic [7:0] requested_copies_q;

  pspr_pkg::in_item_t in_item;
  pspr_pkg::result_t  parse_res;
  pspr_pkg::result_t  out_res;
  logic               can_load;
  logic               fire;
  logic               out_valid;

  // Configuration writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      printer_model_q    <= 1'b0;
      requested_copies_q <= 8'd1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index[0])
        pspr_pkg::CFG_PRINTER_MODEL:    printer_model_q    <= cfg_i.data[0];
        pspr_pkg::CFG_REQUESTED_COPIES: requested_copies_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Move the held byte on when the result register has room
  assign fire = in_item.valid && can_load;

  pspr_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_i.valid),
    .data_byte_i  (in_i.data_byte),
    .stream_end_i (in_i.stream_end),
    .take_i       (can_load),
    .ready_o      (in_i.ready),
    .item_o       (in_item)
  );

  pspr_parser u_parser (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .fire_i             (fire),
    .data_byte_i        (in_item.data_byte),
    .stream_end_i       (in_item.stream_end),
    .printer_model_i    (printer_model_q),
    .requested_copies_i (requested_copies_q),
    .result_o           (parse_res)
  );

  pspr_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire),
    .result_i   (parse_res),
    .ready_i    (out_o.ready),
    .can_load_o (can_load),
    .valid_o    (out_valid),
    .result_o   (out_res)
  );

  assign out_o.valid         = out_valid;
  assign out_o.out_byte      = out_res.out_byte;
  assign out_o.record_kind   = out_res.record_kind;
  assign out_o.header_number = out_res.header_number;
  assign out_o.byte_index    = out_res.byte_index;
  assign out_o.record_last   = out_res.record_last;
  assign out_o.job_done      = out_res.job_done;
  assign out_o.error_code    = out_res.error_code;

  // Errors carry no tags
  `PSPR_ASSERT_IMP(a_err_untagged, out_valid && out_res.error_code != pspr_pkg::ERR_OK, out_res.record_kind == pspr_pkg::KIND_ESC && !out_res.record_last && !out_res.job_done, "error result carries tags")
  // Job completion only on the closing footer byte
  `PSPR_ASSERT_IMP(a_done_footer, out_valid && out_res.job_done, out_res.record_last && out_res.record_kind == pspr_pkg::KIND_FOOTER, "job done off a footer end")
  // A held byte stays while the result register is blocked
  `PSPR_ASSERT_NXT(a_in_hold, in_item.valid && !can_load, in_item.valid, "held input byte lost")

endmodule
